// ===== sv/sgdmu_pkg.sv =====
package sgdmu_pkg;

    // field widths
    localparam int IDX_W  = 12;
    localparam int DATA_W = 32;
    localparam int COEF_W = 16;

    // default velocity store depth
    localparam int ELEMENTS_DEF = 4096;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NESTEROV      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY         = 2'd3;

    // saturation limits
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [COEF_W-1:0] learning_rate;
        logic [COEF_W-1:0] momentum_factor;
        logic              use_nesterov;
        logic [COEF_W-1:0] decay_factor;
    } cfg_t;

    // floor(x * c / 2^16), always fits in DATA_W bits
    function automatic logic signed [DATA_W-1:0] qmul(
        input logic signed [DATA_W-1:0] x,
        input logic [COEF_W-1:0]        c
    );
        logic signed [COEF_W:0]        cs;
        logic signed [DATA_W+COEF_W:0] p;
        cs = {1'b0, c};
        p  = x * cs;
        return p[DATA_W+COEF_W-1:COEF_W];
    endfunction

    // clamp a one-bit-wider sum into the signed range
    function automatic logic signed [DATA_W-1:0] sat_wide(
        input logic signed [DATA_W:0] s
    );
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] add_sat(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        return sat_wide(s);
    endfunction

    function automatic logic signed [DATA_W-1:0] sub_sat(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        return sat_wide(s);
    endfunction

endpackage

// ===== sv/sgdmu_vel_store.sv =====
module sgdmu_vel_store #(
    parameter int ELEMENTS = sgdmu_pkg::ELEMENTS_DEF,
    parameter int ADDR_W   = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             rd_en,
    input  logic [ADDR_W-1:0]                rd_addr,
    output logic signed [sgdmu_pkg::DATA_W-1:0] rd_data,
    input  logic                             wr_en,
    input  logic [ADDR_W-1:0]                wr_addr,
    input  logic signed [sgdmu_pkg::DATA_W-1:0] wr_data,
    output logic                             clearing
);
    import sgdmu_pkg::*;

    logic signed [DATA_W-1:0] vel_mem [ELEMENTS];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]        clr_addr_reg;
    logic                     clearing_reg;

    // zero sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(ELEMENTS - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // single write port, registered read (read returns old data on collision)
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            vel_mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            vel_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= vel_mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

    a_no_write_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !wr_en)
        else $error("velocity write during clearing sweep");

endmodule

// ===== sv/sgdmu_pipe.sv =====
module sgdmu_pipe #(
    parameter int ELEMENTS = sgdmu_pkg::ELEMENTS_DEF,
    parameter int ADDR_W   = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  sgdmu_pkg::cfg_t                     cfg,
    input  logic                                in_valid,
    input  logic [sgdmu_pkg::IDX_W-1:0]         in_idx,
    input  logic signed [sgdmu_pkg::DATA_W-1:0] in_grad,
    input  logic signed [sgdmu_pkg::DATA_W-1:0] in_weight,
    output logic                                rd_en,
    output logic [ADDR_W-1:0]                   rd_addr,
    input  logic signed [sgdmu_pkg::DATA_W-1:0] rd_data,
    output logic                                wr_en,
    output logic [ADDR_W-1:0]                   wr_addr,
    output logic signed [sgdmu_pkg::DATA_W-1:0] wr_data,
    output logic                                out_valid,
    output logic [sgdmu_pkg::IDX_W-1:0]         out_idx,
    output logic signed [sgdmu_pkg::DATA_W-1:0] out_weight
);
    import sgdmu_pkg::*;

    localparam int HIST_DEPTH = 3;

    logic mom_on;
    logic in_store;

    // stage 1: inputs, velocity read in flight
    logic                     s1_vld_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic signed [DATA_W-1:0] s1_grad_reg;
    logic signed [DATA_W-1:0] s1_w_reg;
    logic                     s1_in_reg;
    // stage 2: decay product ready, velocity captured
    logic                     s2_vld_reg;
    logic [IDX_W-1:0]         s2_idx_reg;
    logic signed [DATA_W-1:0] s2_grad_reg;
    logic signed [DATA_W-1:0] s2_w_reg;
    logic                     s2_in_reg;
    logic signed [DATA_W-1:0] s2_qd_reg;
    logic signed [DATA_W-1:0] s2_vel_reg;
    // stage 3: velocity read-modify-write
    logic                     s3_vld_reg;
    logic [IDX_W-1:0]         s3_idx_reg;
    logic signed [DATA_W-1:0] s3_w_reg;
    logic                     s3_in_reg;
    logic signed [DATA_W-1:0] s3_g_reg;
    logic signed [DATA_W-1:0] s3_vel_reg;
    // stage 4: look-ahead product
    logic                     s4_vld_reg;
    logic [IDX_W-1:0]         s4_idx_reg;
    logic signed [DATA_W-1:0] s4_w_reg;
    logic signed [DATA_W-1:0] s4_g_reg;
    logic signed [DATA_W-1:0] s4_v_reg;
    // stage 5: step select
    logic                     s5_vld_reg;
    logic [IDX_W-1:0]         s5_idx_reg;
    logic signed [DATA_W-1:0] s5_w_reg;
    logic signed [DATA_W-1:0] s5_g_reg;
    logic signed [DATA_W-1:0] s5_v_reg;
    logic signed [DATA_W-1:0] s5_nq_reg;
    // stage 6: learning rate product
    logic                     s6_vld_reg;
    logic [IDX_W-1:0]         s6_idx_reg;
    logic signed [DATA_W-1:0] s6_w_reg;
    logic signed [DATA_W-1:0] s6_step_reg;
    // stage 7: final subtract
    logic                     s7_vld_reg;
    logic [IDX_W-1:0]         s7_idx_reg;
    logic signed [DATA_W-1:0] s7_w_reg;
    logic signed [DATA_W-1:0] s7_ql_reg;

    // recent velocity writes that the captured read data missed
    logic [HIST_DEPTH-1:0]    hist_vld_reg;
    logic [IDX_W-1:0]         hist_idx_reg [HIST_DEPTH];
    logic signed [DATA_W-1:0] hist_v_reg   [HIST_DEPTH];

    logic signed [DATA_W-1:0] s2_g_next;
    logic signed [DATA_W-1:0] v_old;
    logic signed [DATA_W-1:0] v_new_next;
    logic signed [DATA_W-1:0] step_next;

    assign mom_on   = (cfg.momentum_factor != '0);
    assign in_store = (32'(in_idx) < 32'(ELEMENTS));

    // velocity read at accept
    assign rd_en   = en && in_valid && in_store;
    assign rd_addr = ADDR_W'(in_idx);

    // gradient plus weight decay
    assign s2_g_next = add_sat(s2_grad_reg, s2_qd_reg);

    // forward the newest matching write over the stored value
    always_comb begin
        v_old = s3_vel_reg;
        for (int i = HIST_DEPTH - 1; i >= 0; i--) begin
            if (hist_vld_reg[i] && hist_idx_reg[i] == s3_idx_reg) begin
                v_old = hist_v_reg[i];
            end
        end
    end

    assign v_new_next = add_sat(qmul(v_old, cfg.momentum_factor), s3_g_reg);

    assign wr_en   = en && s3_vld_reg && s3_in_reg && mom_on;
    assign wr_addr = ADDR_W'(s3_idx_reg);
    assign wr_data = v_new_next;

    // step select
    always_comb begin
        if (!mom_on) begin
            step_next = s5_g_reg;
        end else if (cfg.use_nesterov) begin
            step_next = add_sat(s5_g_reg, s5_nq_reg);
        end else begin
            step_next = s5_v_reg;
        end
    end

    // valid bits and write history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_vld_reg   <= 1'b0;
            s5_vld_reg   <= 1'b0;
            s6_vld_reg   <= 1'b0;
            s7_vld_reg   <= 1'b0;
            hist_vld_reg <= '0;
        end else if (en) begin
            s1_vld_reg   <= in_valid;
            s2_vld_reg   <= s1_vld_reg;
            s3_vld_reg   <= s2_vld_reg;
            s4_vld_reg   <= s3_vld_reg;
            s5_vld_reg   <= s4_vld_reg;
            s6_vld_reg   <= s5_vld_reg;
            s7_vld_reg   <= s6_vld_reg;
            hist_vld_reg <= {hist_vld_reg[HIST_DEPTH-2:0], wr_en};
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_idx_reg  <= in_idx;
            s1_grad_reg <= in_grad;
            s1_w_reg    <= in_weight;
            s1_in_reg   <= in_store;

            s2_idx_reg  <= s1_idx_reg;
            s2_grad_reg <= s1_grad_reg;
            s2_w_reg    <= s1_w_reg;
            s2_in_reg   <= s1_in_reg;
            s2_qd_reg   <= qmul(s1_w_reg, cfg.decay_factor);
            s2_vel_reg  <= s1_in_reg ? rd_data : '0;

            s3_idx_reg  <= s2_idx_reg;
            s3_w_reg    <= s2_w_reg;
            s3_in_reg   <= s2_in_reg;
            s3_g_reg    <= s2_g_next;
            s3_vel_reg  <= s2_vel_reg;

            s4_idx_reg  <= s3_idx_reg;
            s4_w_reg    <= s3_w_reg;
            s4_g_reg    <= s3_g_reg;
            s4_v_reg    <= v_new_next;

            s5_idx_reg  <= s4_idx_reg;
            s5_w_reg    <= s4_w_reg;
            s5_g_reg    <= s4_g_reg;
            s5_v_reg    <= s4_v_reg;
            s5_nq_reg   <= qmul(s4_v_reg, cfg.momentum_factor);

            s6_idx_reg  <= s5_idx_reg;
            s6_w_reg    <= s5_w_reg;
            s6_step_reg <= step_next;

            s7_idx_reg  <= s6_idx_reg;
            s7_w_reg    <= s6_w_reg;
            s7_ql_reg   <= qmul(s6_step_reg, cfg.learning_rate);

            hist_idx_reg[0] <= s3_idx_reg;
            hist_v_reg[0]   <= v_new_next;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                hist_idx_reg[i] <= hist_idx_reg[i-1];
                hist_v_reg[i]   <= hist_v_reg[i-1];
            end
        end
    end

    assign out_valid  = s7_vld_reg;
    assign out_idx    = s7_idx_reg;
    assign out_weight = sub_sat(s7_w_reg, s7_ql_reg);

    a_hist_tracks_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> hist_vld_reg[0] && hist_v_reg[0] == $past(wr_data))
        else $error("write history lost a velocity write");

    a_stall_holds_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(s7_vld_reg) && $stable(hist_vld_reg))
        else $error("pipeline moved while stalled");

endmodule

// ===== sv/sgd_momentum_update.sv =====
// throughput: one word per cycle unless a held result or the store clear
//   stalls it; the velocity read-modify-write closes in one stage with
//   forwarding from the last three writes, so equal indexes stream
// reset: synchronous active-low; config registers clear to zero, then the
//   velocity store is zeroed one entry per cycle (s_ready low meanwhile)
module sgd_momentum_update #(
    parameter int ELEMENTS = sgdmu_pkg::ELEMENTS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sgdmu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sgdmu_pkg::COEF_W-1:0]           cfg_data,
    // input words
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [sgdmu_pkg::IDX_W-1:0]            s_element_index,
    input  logic signed [sgdmu_pkg::DATA_W-1:0]    s_gradient,
    input  logic signed [sgdmu_pkg::DATA_W-1:0]    s_old_weight,
    // result words
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [sgdmu_pkg::IDX_W-1:0]            m_result_index,
    output logic signed [sgdmu_pkg::DATA_W-1:0]    m_new_weight
);
    import sgdmu_pkg::*;

    localparam int ADDR_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

    cfg_t                     cfg_reg;
    logic                     clearing;
    logic                     en;
    logic                     accept;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     tail_vld;
    logic [IDX_W-1:0]         tail_idx;
    logic signed [DATA_W-1:0] tail_weight;
    logic                     out_vld_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic signed [DATA_W-1:0] out_weight_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LEARNING_RATE: cfg_reg.learning_rate   <= cfg_data;
                CFG_MOMENTUM:      cfg_reg.momentum_factor <= cfg_data;
                CFG_NESTEROV:      cfg_reg.use_nesterov    <= cfg_data[0];
                CFG_DECAY:         cfg_reg.decay_factor    <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless its tail would overwrite a held result
    assign en      = !(out_vld_reg && !m_ready && tail_vld);
    assign s_ready = en && !clearing;
    assign accept  = s_valid && s_ready;

    sgdmu_vel_store #(
        .ELEMENTS (ELEMENTS),
        .ADDR_W   (ADDR_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    sgdmu_pipe #(
        .ELEMENTS (ELEMENTS),
        .ADDR_W   (ADDR_W)
    ) u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .cfg        (cfg_reg),
        .in_valid   (accept),
        .in_idx     (s_element_index),
        .in_grad    (s_gradient),
        .in_weight  (s_old_weight),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_valid  (tail_vld),
        .out_idx    (tail_idx),
        .out_weight (tail_weight)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en && tail_vld) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && tail_vld) begin
            out_idx_reg    <= tail_idx;
            out_weight_reg <= tail_weight;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_result_index = out_idx_reg;
    assign m_new_weight   = out_weight_reg;

    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_ready)
        else $error("input taken before velocity store was cleared");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sgdmu_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] grad;
        logic signed [DATA_W-1:0] weight;
    } update_word_t;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] weight;
    } weight_word_t;

    typedef struct {
        logic [CFG_IDX_W-1:0] sel;
        logic [COEF_W-1:0]    value;
    } cfg_word_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [COEF_W-1:0]        cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [IDX_W-1:0]         s_element_index = '0;
    logic signed [DATA_W-1:0] s_gradient = '0;
    logic signed [DATA_W-1:0] s_old_weight = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [IDX_W-1:0]         m_result_index;
    logic signed [DATA_W-1:0] m_new_weight;

    // stimulus and expectation stores
    update_word_t update_pending[$];
    cfg_word_t    cfg_pending[$];
    weight_word_t weight_expect_q[$];

    // shadow of the optimizer state
    logic [COEF_W-1:0]        lr_shadow = '0;
    logic [COEF_W-1:0]        momentum_shadow = '0;
    logic                     nesterov_shadow = 1'b0;
    logic [COEF_W-1:0]        decay_shadow = '0;
    logic signed [DATA_W-1:0] velocity_shadow [ELEMENTS_DEF];

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int updates_sent = 0;
    int weights_checked = 0;
    int settings_used = 0;
    logic [IDX_W-1:0] recent_index = '0;

    update_word_t drv_word;
    cfg_word_t    drv_cfg;
    weight_word_t mon_expect;

    sgd_momentum_update dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_index (s_element_index),
        .s_gradient      (s_gradient),
        .s_old_weight    (s_old_weight),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_index  (m_result_index),
        .m_new_weight    (m_new_weight)
    );

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // floor(x * c / 2^16)
    function automatic longint coef_scale(input longint x, input logic [COEF_W-1:0] c);
        longint p;
        p = x * longint'(c);
        return p >>> 16;
    endfunction

    function automatic longint clamp32(input longint s);
        if (s > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (s < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return s;
    endfunction

    // weight after one optimizer step; updates the shadow velocity
    function automatic logic signed [DATA_W-1:0] stepped_weight(
        input logic [IDX_W-1:0]         idx,
        input logic signed [DATA_W-1:0] grad,
        input logic signed [DATA_W-1:0] w
    );
        longint g;
        longint stride;
        longint vel;
        longint nw;
        g = clamp32(longint'(grad) + coef_scale(longint'(w), decay_shadow));
        stride = g;
        if (momentum_shadow != 0) begin
            vel = clamp32(coef_scale(longint'(velocity_shadow[idx]), momentum_shadow) + g);
            velocity_shadow[idx] = vel[DATA_W-1:0];
            if (nesterov_shadow) begin
                stride = clamp32(g + coef_scale(vel, momentum_shadow));
            end else begin
                stride = vel;
            end
        end
        nw = clamp32(longint'(w) - coef_scale(stride, lr_shadow));
        return nw[DATA_W-1:0];
    endfunction

    // driver: config words and update words
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
            s_valid <= 1'b0;
        end else begin
            // config word taken
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LEARNING_RATE: lr_shadow = cfg_data;
                    CFG_MOMENTUM:      momentum_shadow = cfg_data;
                    CFG_NESTEROV:      nesterov_shadow = cfg_data[0];
                    CFG_DECAY:         decay_shadow = cfg_data;
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (cfg_pending.size() != 0) begin
                    drv_cfg = cfg_pending.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= drv_cfg.sel;
                    cfg_data <= drv_cfg.value;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
            // update word taken: predict its result
            if (s_valid && s_ready) begin
                mon_expect.idx = s_element_index;
                mon_expect.weight = stepped_weight(s_element_index, s_gradient, s_old_weight);
                weight_expect_q.push_back(mon_expect);
                updates_sent++;
            end
            if (!s_valid || s_ready) begin
                if (update_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    drv_word = update_pending.pop_front();
                    s_valid <= 1'b1;
                    s_element_index <= drv_word.idx;
                    s_gradient <= drv_word.grad;
                    s_old_weight <= drv_word.weight;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (weight_expect_q.size() == 0) begin
                    $error("result word with no update pending: index %0d", m_result_index);
                    mismatches++;
                end else begin
                    weight_word_t exp_w;
                    exp_w = weight_expect_q.pop_front();
                    weights_checked++;
                    if (m_result_index !== exp_w.idx) begin
                        $error("result_index: expected %0d, got %0d", exp_w.idx, m_result_index);
                        mismatches++;
                    end
                    if (m_new_weight !== exp_w.weight) begin
                        $error("new_weight: expected %0d, got %0d", exp_w.weight, m_new_weight);
                        mismatches++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_update(
        input logic [IDX_W-1:0]         idx,
        input logic signed [DATA_W-1:0] grad,
        input logic signed [DATA_W-1:0] w
    );
        update_word_t u;
        u.idx = idx;
        u.grad = grad;
        u.weight = w;
        update_pending.push_back(u);
    endtask

    // write all four registers while the block is idle
    task automatic write_settings(
        input logic [COEF_W-1:0] lr,
        input logic [COEF_W-1:0] mom,
        input logic              nest,
        input logic [COEF_W-1:0] dec
    );
        cfg_word_t c;
        c.sel = CFG_LEARNING_RATE; c.value = lr;          cfg_pending.push_back(c);
        c.sel = CFG_MOMENTUM;      c.value = mom;         cfg_pending.push_back(c);
        c.sel = CFG_NESTEROV;      c.value = {15'd0, nest}; cfg_pending.push_back(c);
        c.sel = CFG_DECAY;         c.value = dec;         cfg_pending.push_back(c);
        while (cfg_pending.size() != 0 || cfg_valid) begin
            @(posedge aclk);
        end
        settings_used++;
    endtask

    // let every queued update through and every result back out
    task automatic drain_updates();
        while (update_pending.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (weight_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (12) @(posedge aclk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return COEF_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // mostly a few hot elements so velocities build up and indexes repeat
    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: recent_index = IDX_W'($urandom_range(7));
            5:             recent_index = recent_index;
            6:             recent_index = $urandom_range(1) ? '1 : '0;
            default:       recent_index = IDX_W'($urandom_range(4095));
        endcase
        return recent_index;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int near;
        case ($urandom_range(15))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return '0;
            3: return '1;
            4, 5, 6, 7, 8: begin
                near = int'($urandom_range(2097152)) - 1048576;
                return near;
            end
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial begin
        int p;
        int k;
        logic [COEF_W-1:0] mom;
        for (k = 0; k < ELEMENTS_DEF; k++) begin
            velocity_shadow[k] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // momentum off, heavy decay and full step: saturation at both ends
        write_settings(16'hFFFF, 16'h0000, 1'b0, 16'hFFFF);
        add_update(12'd0,    SAT_MAX, SAT_MAX);
        add_update(12'd1,    SAT_MIN, SAT_MIN);
        add_update(12'd2,    '0, '0);
        add_update(12'd4095, '1, SAT_MAX);
        add_update(12'd5,    SAT_MAX, SAT_MIN);
        add_update(12'd6,    SAT_MIN, SAT_MAX);
        add_update(12'd7,    32'sh0001_0000, 32'sh0001_0000);
        add_update(12'd8,    '1, '1);
        add_update(12'd9,    32'h5555_5555, 32'hAAAA_AAAA);
        add_update(12'd10,   32'hAAAA_AAAA, 32'h5555_5555);
        drain_updates();

        // full momentum with look-ahead: velocity of one element runs into both rails
        write_settings(16'h0000, 16'hFFFF, 1'b1, 16'h0000);
        for (k = 0; k < 4; k++) begin
            add_update(12'd3, SAT_MAX, 32'sh0000_8000);
        end
        for (k = 0; k < 4; k++) begin
            add_update(12'd3, SAT_MIN, -32'sh0000_8000);
        end
        drain_updates();

        // plain momentum, tiny factor, stored velocity carried over
        write_settings(16'hFFFF, 16'h0001, 1'b0, 16'h8000);
        add_update(12'd3,    32'sh0002_0000, 32'sh0001_0000);
        add_update(12'd3,    -32'sh0002_0000, '0);
        add_update(12'd4095, SAT_MIN, SAT_MIN);
        add_update(12'd4095, SAT_MAX, SAT_MAX);
        add_update(12'd0,    '1, SAT_MIN);
        add_update(12'd1,    32'sh0000_0001, '1);
        drain_updates();

        // random phases, each with its own settings, over four idle patterns
        for (p = 0; p < 8; p++) begin
            sender_idle_pct = 0;
            recv_stall_pct = 0;
            if (p == 1) begin
                mom = '0;
            end else if (p == 5) begin
                mom = '1;
            end else begin
                mom = pick_coef();
            end
            write_settings(pick_coef(), mom, p[2], pick_coef());
            case (p % 4)
                1: sender_idle_pct = 87;
                2: recv_stall_pct = 87;
                3: begin
                    sender_idle_pct = 6;
                    recv_stall_pct = 6;
                end
                default: ;
            endcase
            for (k = 0; k < 185; k++) begin
                add_update(pick_index(), pick_value(), pick_value());
            end
            drain_updates();
        end

        $display("covered %0d weight updates under %0d register settings, %0d results checked",
                 updates_sent, settings_used, weights_checked);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sgdmu_pkg.sv
sv/sgdmu_vel_store.sv
sv/sgdmu_pipe.sv
sv/sgd_momentum_update.sv
tb/sv/testbench.sv
